// ===== sv/box_header_walker_core_defines.svh =====
// assertion macros shared by the walker rtl
`ifndef BOX_HEADER_WALKER_CORE_DEFINES_SVH
`define BOX_HEADER_WALKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BHW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("box header walker check failed");
`define BHW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("box header walker check failed");
`else
`define BHW_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BHW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/bhw_pkg.sv =====
package bhw_pkg;

  localparam int unsigned FieldW = 48;
  localparam int unsigned WordW  = 32;
  localparam int unsigned LargeW = 64;

  typedef logic [FieldW-1:0] field_t;
  typedef logic [WordW-1:0]  word_t;
  typedef logic [LargeW-1:0] large_t;
  typedef logic [4:0]        hdr_cnt_t;
  typedef logic [0:0]        reg_index_t;

  // register indexes
  localparam reg_index_t REG_FILE_LENGTH = 1'b0;
  localparam reg_index_t REG_BASE_OFFSET = 1'b1;

  // header byte counts
  localparam hdr_cnt_t CNT_SIZE_DONE  = 5'd4;
  localparam hdr_cnt_t CNT_KIND_LAST  = 5'd7;
  localparam hdr_cnt_t CNT_KIND_DONE  = 5'd8;
  localparam hdr_cnt_t CNT_LARGE_LAST = 5'd15;

  // size field codes and header lengths
  localparam word_t  SIZE_TO_END   = 32'd0;
  localparam word_t  SIZE_LARGE    = 32'd1;
  localparam word_t  SIZE_MIN_OK   = 32'd8;
  localparam large_t HDR_LEN_SHORT = 64'd8;
  localparam large_t HDR_LEN_LARGE = 64'd16;

endpackage

// ===== sv/box_header_walker_core.sv =====
// channel  | ports                                              | accepted when
// ---------+----------------------------------------------------+--------------------
// input    | in_valid, in_stall, in_data_byte                   | in_valid & !in_stall
// result   | out_valid, out_stall, out_box_kind, out_payload_*  | out_valid & !out_stall
// config   | cfg_we, cfg_index, cfg_wdata                       | cfg_we
//
// one byte a cycle unless stalled; a result is registered in the cycle after its last header byte
// the limit is the position add and saturating next-box compare in the single state update
// in_stall is high only while a result sits in the output register and out_stall is high
// synchronous reset clears state, config, counters, out_valid and the halt flag, not output data; no clearing pass
// after a malformed request the walker drops every byte until reset
`include "box_header_walker_core_defines.svh"

module box_header_walker_core #(
  parameter int unsigned POSITION_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  bhw_pkg::reg_index_t   cfg_index,
  input  bhw_pkg::field_t       cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bhw_pkg::word_t        out_box_kind,
  output bhw_pkg::field_t       out_payload_offset,
  output bhw_pkg::field_t       out_payload_size,
  output logic                  out_malformed
);
  import bhw_pkg::*;

  localparam int unsigned PB = POSITION_BITS;
  localparam large_t POS_MASK = {LargeW{1'b1}} >> (LargeW - PB);

  field_t   flen_r, base_r;
  logic [PB-1:0] pos_r, pos_nxt, next_r, next_nxt;
  hdr_cnt_t cnt_r, cnt_nxt;
  word_t    size_r, size_nxt, kind_r, kind_nxt;
  large_t   large_r, large_nxt;
  logic     halted_r, halted_nxt;

  logic     out_valid_r;
  word_t    out_kind_r;
  field_t   out_off_r, out_size_r;
  logic     out_bad_r;

  logic     accept, live;
  large_t   pos64, flen_m, hdr_end, payload;
  logic [LargeW:0] sum;
  logic     res_vld, res_bad, set_next;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign pos64    = LargeW'(pos_r);
  assign flen_m   = LargeW'(flen_r) & POS_MASK;
  assign live     = accept & ~halted_r & (pos64 < flen_m);
  assign hdr_end  = pos64 + 64'd1;

  always_comb begin
    pos_nxt    = pos_r;
    next_nxt   = next_r;
    cnt_nxt    = cnt_r;
    size_nxt   = size_r;
    kind_nxt   = kind_r;
    large_nxt  = large_r;
    halted_nxt = halted_r;
    payload    = '0;
    sum        = '0;
    res_vld    = 1'b0;
    res_bad    = 1'b0;
    set_next   = 1'b0;
    if (live) begin
      pos_nxt = hdr_end[PB-1:0];
      if (pos64 >= LargeW'(next_r)) begin
        if (cnt_r < CNT_SIZE_DONE) begin
          size_nxt = {size_r[WordW-9:0], in_data_byte};
          cnt_nxt  = cnt_r + 5'd1;
        end else if (cnt_r < CNT_KIND_DONE) begin
          kind_nxt = {kind_r[WordW-9:0], in_data_byte};
          cnt_nxt  = cnt_r + 5'd1;
          if (cnt_r == CNT_KIND_LAST) begin
            if (size_r == SIZE_LARGE) begin
              large_nxt = '0;
            end else begin
              cnt_nxt = '0;
              res_vld = 1'b1;
              if (size_r < SIZE_MIN_OK && size_r != SIZE_TO_END) begin
                res_bad    = 1'b1;
                halted_nxt = 1'b1;
              end else begin
                set_next = 1'b1;
                if (size_r == SIZE_TO_END) payload = flen_m - hdr_end;
                else payload = LargeW'(size_r) - HDR_LEN_SHORT;
              end
            end
          end
        end else begin
          large_nxt = {large_r[LargeW-9:0], in_data_byte};
          cnt_nxt   = cnt_r + 5'd1;
          if (cnt_r == CNT_LARGE_LAST) begin
            cnt_nxt = '0;
            res_vld = 1'b1;
            if (large_nxt < HDR_LEN_LARGE || (large_nxt & ~POS_MASK) != '0) begin
              res_bad    = 1'b1;
              halted_nxt = 1'b1;
            end else begin
              set_next = 1'b1;
              payload  = large_nxt - HDR_LEN_LARGE;
            end
          end
        end
      end
    end
    if (set_next) begin
      sum = {1'b0, hdr_end} + {1'b0, payload};
      // next header position saturates at the top of the position range
      if (sum > {1'b0, POS_MASK}) next_nxt = POS_MASK[PB-1:0];
      else next_nxt = sum[PB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flen_r      <= '0;
      base_r      <= '0;
      pos_r       <= '0;
      next_r      <= '0;
      cnt_r       <= '0;
      size_r      <= '0;
      kind_r      <= '0;
      large_r     <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FILE_LENGTH: flen_r <= cfg_wdata;
          REG_BASE_OFFSET: base_r <= cfg_wdata;
          default: ;
        endcase
      end
      pos_r       <= pos_nxt;
      next_r      <= next_nxt;
      cnt_r       <= cnt_nxt;
      size_r      <= size_nxt;
      kind_r      <= kind_nxt;
      large_r     <= large_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= res_vld | in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_kind_r <= kind_nxt;
      out_off_r  <= base_r + hdr_end[FieldW-1:0];
      out_size_r <= res_bad ? '0 : payload[FieldW-1:0];
      out_bad_r  <= res_bad;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_box_kind       = out_kind_r;
  assign out_payload_offset = out_off_r;
  assign out_payload_size   = out_size_r;
  assign out_malformed      = out_bad_r;

  `BHW_ASSERT_NEXT(a_halt_sticks, clk, rst_n, halted_r, halted_r)
  `BHW_ASSERT_NEXT(a_bad_halts, clk, rst_n, res_vld && res_bad, halted_r && out_malformed)
  `BHW_ASSERT_SAME(a_halt_cnt_clear, clk, rst_n, halted_r, cnt_r == '0)
  `BHW_ASSERT_SAME(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CNT_LARGE_LAST)
  `BHW_ASSERT_SAME(a_bad_size_zero, clk, rst_n, out_valid_r && out_bad_r, out_size_r == '0)

endmodule
